[rtl/alarm_severity_beeper_assert.svh]
// Assertion macros used by the checker of the alarm severity beeper.
`ifndef ALARM_SEVERITY_BEEPER_ASSERT_SVH
`define ALARM_SEVERITY_BEEPER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define ASB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alarm severity beeper check failed");

// Next-cycle implication, sampled on i_clk and held off during reset.
`define ASB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alarm severity beeper check failed");

`endif

[rtl/asb_pkg.sv]
// Types and constants of the alarm severity beeper.
`timescale 1ns / 1ps

package asb_pkg;

    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_RAISE = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    localparam logic [2:0] SEV_SILENT = 3'd0;
    localparam logic [2:0] SEV_INFO = 3'd1;
    localparam logic [2:0] SEV_WARNING = 3'd2;
    localparam logic [2:0] SEV_ERROR = 3'd3;
    localparam logic [2:0] SEV_CRITICAL = 3'd4;

    localparam logic [9:0] INFO_ON_MS = 10'd100;
    localparam logic [10:0] INFO_OFF_MS = 11'd1000;
    localparam logic [6:0] INFO_LIMIT = 7'd1;
    localparam logic [9:0] WARN_ON_MS = 10'd200;
    localparam logic [10:0] WARN_OFF_MS = 11'd300;
    localparam logic [6:0] WARN_LIMIT = 7'd3;
    localparam logic [9:0] ERROR_ON_MS = 10'd200;
    localparam logic [10:0] ERROR_OFF_MS = 11'd100;
    localparam logic [6:0] ERROR_LIMIT = 7'd3;
    localparam logic [9:0] CRIT_ON_MS = 10'd999;
    localparam logic [10:0] CRIT_OFF_MS = 11'd999;
    localparam logic [6:0] CRIT_LIMIT = 7'd99;

    typedef struct packed {
        logic [2:0] sev;
        logic tone_on;
        logic [6:0] phase_count;
        logic [6:0] phase_limit;
        logic [9:0] on_ms;
        logic [10:0] off_ms;
        logic [31:0] phase_start_ms;
        logic cycle_active;
        logic pin_raw;
    } t_state;

    typedef struct packed {
        logic buzzer_level;
        logic [2:0] severity;
        logic pattern_busy;
    } t_result;

endpackage

[rtl/alarm_severity_beeper.sv]
// Top level of the alarm severity beeper: request register, state and result register.
`timescale 1ns / 1ps

// The block takes one request per clock while the result side is ready and
// returns one result for each: a request is captured in the input register, then
// the severity latch and the beep pattern state are updated in one pass of
// short logic while the result is written to the output register. The output
// register lets a new request in while a finished result waits to be taken,
// so with the result side ready the block sustains one request every cycle.
// A check request (kind 0) runs the pattern timer against its millisecond
// timestamp, kind 1 raises the severity, kind 2 clears it. Write the polarity
// register only while no request is in flight.
module alarm_severity_beeper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_level,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_buzzer_level,
    output logic [2:0]  o_severity,
    output logic        o_pattern_busy
);

    logic r_invert;
    logic r_in_valid;
    logic [1:0] r_kind;
    logic [2:0] r_level;
    logic [31:0] r_now_ms;
    asb_pkg::t_state r_state;
    logic r_out_valid;
    asb_pkg::t_result r_result;

    asb_pkg::t_state n_state;
    asb_pkg::t_result n_result;
    logic advance;

    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    asb_step u_step (
        .i_state  (r_state),
        .i_invert (r_invert),
        .i_kind   (r_kind),
        .i_level  (r_level),
        .i_now_ms (r_now_ms),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state <= '0;
        end else begin
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_level <= i_level;
            r_now_ms <= i_now_ms;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_buzzer_level = r_result.buzzer_level;
    assign o_severity = r_result.severity;
    assign o_pattern_busy = r_result.pattern_busy;

endmodule

[rtl/asb_step.sv]
// Next-state and result logic for one request of the alarm severity beeper.
`timescale 1ns / 1ps

module asb_step (
    input  asb_pkg::t_state  i_state,
    input  logic             i_invert,
    input  logic [1:0]       i_kind,
    input  logic [2:0]       i_level,
    input  logic [31:0]      i_now_ms,
    output asb_pkg::t_state  o_state,
    output asb_pkg::t_result o_result
);

    always_comb begin
        asb_pkg::t_state s;
        logic start;
        logic [6:0] lim;
        logic [9:0] on_ms;
        logic [10:0] off_ms;
        logic crit;
        logic [10:0] span;
        logic [31:0] elapsed;
        logic [2:0] lvl;

        s = i_state;
        start = 1'b0;
        lim = 7'd0;
        on_ms = 10'd0;
        off_ms = 11'd0;
        crit = 1'b0;
        span = 11'd0;
        elapsed = 32'd0;
        lvl = i_level;

        unique case (i_kind)
            asb_pkg::KIND_CHECK: begin
                unique case (s.sev)
                    asb_pkg::SEV_SILENT: begin
                        s.phase_limit = 7'd0;
                        s.cycle_active = 1'b0;
                    end
                    asb_pkg::SEV_INFO: begin
                        start = 1'b1;
                        lim = asb_pkg::INFO_LIMIT;
                        on_ms = asb_pkg::INFO_ON_MS;
                        off_ms = asb_pkg::INFO_OFF_MS;
                        s.sev = asb_pkg::SEV_SILENT;
                    end
                    asb_pkg::SEV_WARNING: begin
                        start = 1'b1;
                        lim = asb_pkg::WARN_LIMIT;
                        on_ms = asb_pkg::WARN_ON_MS;
                        off_ms = asb_pkg::WARN_OFF_MS;
                    end
                    asb_pkg::SEV_ERROR: begin
                        start = 1'b1;
                        lim = asb_pkg::ERROR_LIMIT;
                        on_ms = asb_pkg::ERROR_ON_MS;
                        off_ms = asb_pkg::ERROR_OFF_MS;
                    end
                    default: begin
                        start = 1'b1;
                        lim = asb_pkg::CRIT_LIMIT;
                        on_ms = asb_pkg::CRIT_ON_MS;
                        off_ms = asb_pkg::CRIT_OFF_MS;
                    end
                endcase

                if (start && !s.cycle_active) begin
                    s.phase_count = 7'd0;
                    s.phase_limit = lim;
                    s.on_ms = on_ms;
                    s.off_ms = off_ms;
                    s.tone_on = 1'b1;
                    s.cycle_active = 1'b1;
                end

                // Critical holds the buzzer on whatever phase was running.
                crit = (s.sev == asb_pkg::SEV_CRITICAL);
                if (crit) begin
                    s.tone_on = 1'b1;
                end

                if ((s.phase_count <= s.phase_limit) || crit) begin
                    span = s.tone_on ? {1'b0, s.on_ms} : s.off_ms;
                    elapsed = i_now_ms - s.phase_start_ms;
                    s.pin_raw = s.tone_on;
                    if ((elapsed > {21'd0, span}) && !crit) begin
                        s.tone_on = ~s.tone_on;
                        s.phase_count = s.phase_count + 7'd1;
                        s.phase_start_ms = i_now_ms;
                    end
                end else begin
                    s.pin_raw = 1'b0;
                    s.cycle_active = 1'b0;
                end
            end
            asb_pkg::KIND_RAISE: begin
                if (i_level > asb_pkg::SEV_CRITICAL) begin
                    lvl = asb_pkg::SEV_CRITICAL;
                end
                if (lvl > s.sev) begin
                    s.sev = lvl;
                end
            end
            asb_pkg::KIND_CLEAR: begin
                s.sev = asb_pkg::SEV_SILENT;
            end
            asb_pkg::KIND_IGNORE: begin
                s = i_state;
            end
        endcase

        o_state = s;
        o_result.buzzer_level = s.pin_raw ^ i_invert;
        o_result.severity = s.sev;
        o_result.pattern_busy = s.cycle_active;
    end

endmodule

[rtl/asb_checker.sv]
// Port-level checker for the alarm severity beeper and its bind.
`timescale 1ns / 1ps
`include "alarm_severity_beeper_assert.svh"

module asb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_buzzer_level,
    input logic [2:0]  o_severity,
    input logic        o_pattern_busy
);

    // A delivered severity never leaves the range from silent to critical.
    `ASB_ASSERT_SAME(a_sev_range, o_out_valid, o_severity <= asb_pkg::SEV_CRITICAL)

    // With no result waiting, the block must be able to take a request.
    `ASB_ASSERT_SAME(a_ready_when_empty, !o_out_valid, o_in_ready)

    // A stalled result holds its fields until it is taken.
    `ASB_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_severity) && $stable(o_buzzer_level)
        && $stable(o_pattern_busy))

    // A result goes out only after some request was accepted.
    `ASB_ASSERT_NEXT(a_out_needs_request,
        !o_out_valid && !$past(i_in_valid && o_in_ready), !o_out_valid)

endmodule

bind alarm_severity_beeper asb_checker u_asb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_buzzer_level (o_buzzer_level),
    .o_severity     (o_severity),
    .o_pattern_busy (o_pattern_busy)
);

[dv/tb.sv]
// Self-checking testbench for the alarm severity beeper with a built-in buzzer pattern predictor.
`timescale 1ns / 1ps

module tb;
    import asb_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 270;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_kind = KIND_CHECK;
    logic [2:0]  i_level = SEV_SILENT;
    logic [31:0] i_now_ms = 32'd0;
    logic        i_out_ready = 1'b1;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_buzzer_level;
    logic [2:0]  o_severity;
    logic        o_pattern_busy;

    // Predicted beeper state.
    logic        invert_q = 1'b0;
    logic [2:0]  sev_q = SEV_SILENT;
    logic        tone_q = 1'b0;
    logic [6:0]  count_q = 7'd0;
    logic [6:0]  limit_q = 7'd0;
    logic [9:0]  on_q = 10'd0;
    logic [10:0] off_q = 11'd0;
    logic [31:0] start_q = 32'd0;
    logic        busy_q = 1'b0;
    logic        pin_q = 1'b0;

    t_result     awaited_status[$];
    int          mismatches = 0;
    int          requests_sent = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          sender_gappy = 1'b0;
    int          ready_mode = 0;
    logic [7:0]  stall_pattern = 8'hFF;
    logic [2:0]  stall_phase = 3'd0;
    logic [31:0] clock_ms = 32'd0;

    alarm_severity_beeper u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_level        (i_level),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_buzzer_level (o_buzzer_level),
        .o_severity     (o_severity),
        .o_pattern_busy (o_pattern_busy)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic load_pattern(input logic [9:0] on_ms, input logic [6:0] limit,
                                input logic [10:0] off_ms);
        if (!busy_q) begin
            count_q = 7'd0;
            limit_q = limit;
            on_q = on_ms;
            off_q = off_ms;
            tone_q = 1'b1;
            busy_q = 1'b1;
        end
    endtask

    task automatic step_alarm_state(input logic [1:0] kind, input logic [2:0] level,
                                    input logic [31:0] now, output t_result status);
        logic        crit;
        logic [31:0] span;
        logic [2:0]  lvl;
        case (kind)
            KIND_CHECK: begin
                case (sev_q)
                    SEV_SILENT: begin
                        limit_q = 7'd0;
                        busy_q = 1'b0;
                    end
                    SEV_INFO: begin
                        load_pattern(INFO_ON_MS, INFO_LIMIT, INFO_OFF_MS);
                        sev_q = SEV_SILENT;
                    end
                    SEV_WARNING: load_pattern(WARN_ON_MS, WARN_LIMIT, WARN_OFF_MS);
                    SEV_ERROR: load_pattern(ERROR_ON_MS, ERROR_LIMIT, ERROR_OFF_MS);
                    default: load_pattern(CRIT_ON_MS, CRIT_LIMIT, CRIT_OFF_MS);
                endcase
                crit = (sev_q == SEV_CRITICAL);
                if (crit) tone_q = 1'b1;
                if (count_q <= limit_q || crit) begin
                    span = tone_q ? 32'(on_q) : 32'(off_q);
                    pin_q = tone_q;
                    if ((now - start_q) > span && !crit) begin
                        tone_q = ~tone_q;
                        count_q = count_q + 7'd1;
                        start_q = now;
                    end
                end else begin
                    pin_q = 1'b0;
                    busy_q = 1'b0;
                end
            end
            KIND_RAISE: begin
                lvl = (level > SEV_CRITICAL) ? SEV_CRITICAL : level;
                if (lvl > sev_q) sev_q = lvl;
            end
            KIND_CLEAR: sev_q = SEV_SILENT;
            default: ;
        endcase
        status.buzzer_level = pin_q ^ invert_q;
        status.severity = sev_q;
        status.pattern_busy = busy_q;
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [2:0] level,
                                input logic [31:0] now);
        t_result status;
        int      gap;
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_level <= level;
        i_now_ms <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        step_alarm_state(kind, level, now, status);
        awaited_status.push_back(status);
        requests_sent++;
        if (sender_gappy) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(0, 12);
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_polarity(input logic value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        invert_q = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
    endtask

    // Advances the millisecond clock, mostly near the pattern thresholds, and sends a check.
    task automatic send_check();
        case ($urandom_range(0, 11))
            0, 1: clock_ms += $urandom_range(0, 20);
            2, 3: clock_ms += $urandom_range(90, 110);
            4, 5: clock_ms += $urandom_range(190, 310);
            6, 7: clock_ms += $urandom_range(990, 1010);
            8, 9, 10: clock_ms += $urandom_range(0, 1200);
            default: clock_ms += $urandom;
        endcase
        send_request(KIND_CHECK, 3'($urandom), clock_ms);
    endtask

    task automatic run_alarm_episode();
        logic [2:0] lvl;
        int         checks;
        if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        lvl = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
        send_request(KIND_RAISE, lvl, $urandom);
        checks = $urandom_range(4, 30);
        repeat (checks) begin
            case ($urandom_range(0, 24))
                0: send_request(KIND_CLEAR, 3'($urandom), $urandom);
                1: send_request(KIND_RAISE, 3'($urandom_range(1, 4)), $urandom);
                2: send_request(KIND_IGNORE, 3'($urandom), $urandom);
                default: send_check();
            endcase
        end
        if ($urandom_range(0, 1) == 0) send_request(KIND_CLEAR, 3'($urandom), $urandom);
    endtask

    task automatic test_directed();
        send_request(KIND_CHECK, 3'b111, 32'd0);
        send_request(KIND_RAISE, SEV_SILENT, 32'd0);
        send_request(KIND_RAISE, SEV_INFO, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd101);
        send_request(KIND_CHECK, SEV_SILENT, 32'd1102);
        send_request(KIND_CHECK, SEV_SILENT, 32'd1103);
        send_request(KIND_RAISE, 3'b111, 32'd1103);
        send_request(KIND_IGNORE, SEV_WARNING, 32'hFFFF_FFFF);
        send_request(KIND_CHECK, SEV_SILENT, 32'hFFFF_FFFF);
        send_request(KIND_RAISE, SEV_WARNING, 32'd0);
        send_request(KIND_CLEAR, SEV_SILENT, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'hFFFF_FFFF);
        send_request(KIND_CHECK, SEV_SILENT, 32'h0000_0400);
        send_request(KIND_RAISE, SEV_ERROR, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd2000);
        send_request(KIND_CHECK, SEV_SILENT, 32'd2201);
        send_request(KIND_CHECK, SEV_SILENT, 32'd2250);
        send_request(KIND_RAISE, SEV_CRITICAL, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd2260);
        send_request(KIND_CLEAR, SEV_SILENT, 32'd0);
        send_request(KIND_RAISE, SEV_WARNING, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd5000);
        send_request(KIND_CHECK, SEV_SILENT, 32'd5201);
    endtask

    task automatic test_polarity();
        set_polarity(1'b1);
        send_request(KIND_CHECK, SEV_SILENT, 32'd5300);
        send_request(KIND_RAISE, SEV_CRITICAL, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd5400);
        send_request(KIND_IGNORE, SEV_SILENT, 32'd0);
        send_request(KIND_CLEAR, SEV_SILENT, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd7000);
        send_request(KIND_CHECK, SEV_SILENT, 32'd7001);
        set_polarity(1'b0);
        send_request(KIND_RAISE, SEV_CRITICAL, 32'd0);
        send_request(KIND_CHECK, SEV_SILENT, 32'd7100);
        send_request(KIND_CLEAR, SEV_SILENT, 32'd0);
    endtask

    task automatic test_random_patterns();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            set_polarity(phase[0] ? 1'b0 : 1'b1);
            sender_gappy = (phase != 1);
            ready_mode = (phase == 2) ? 0 : 1;
            target = requests_sent + ITEMS_PER_PHASE;
            while (requests_sent < target) begin
                if ($urandom_range(0, 6) == 0)
                    send_request(2'($urandom), 3'($urandom), $urandom);
                else
                    run_alarm_episode();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_phase == 3'd0) stall_pattern <= 8'($urandom) | 8'($urandom);
        stall_phase <= stall_phase + 3'd1;
        i_out_ready <= (ready_mode == 0) ? 1'b1 : stall_pattern[stall_phase];
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_status.size() == 0) begin
                note_mismatch("unexpected result", 32'd0, 32'd1);
            end else begin
                want = awaited_status.pop_front();
                if (o_buzzer_level !== want.buzzer_level)
                    note_mismatch("buzzer_level", want.buzzer_level, o_buzzer_level);
                if (o_severity !== want.severity)
                    note_mismatch("severity", want.severity, o_severity);
                if (o_pattern_busy !== want.pattern_busy)
                    note_mismatch("pattern_busy", want.pattern_busy, o_pattern_busy);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_polarity();
        test_random_patterns();
        wait_idle();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/asb_pkg.sv
rtl/asb_step.sv
rtl/alarm_severity_beeper.sv
rtl/asb_checker.sv
dv/tb.sv
